// File: src/arsp_pkg.sv
// Package for the adjacency record stream parser.
// Payload structs and result codes; no dependencies.
package arsp_pkg;

    localparam int unsigned CountW = 33;
    localparam int unsigned IdW    = 32;

    localparam logic       KIND_EDGE    = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } t_in_item;

    typedef struct packed {
        logic              result_kind;
        logic [IdW-1:0]    source_node;
        logic [IdW-1:0]    target_node;
        logic [CountW-1:0] node_total;
        logic [1:0]        status;
        logic              last_of_run;
    } t_out_item;

endpackage

// File: src/adjacency_record_stream_parser.sv
// Adjacency record stream parser: LEB128 degree plus 32-bit id decoder.
// Depends on arsp_pkg.
//
// Takes one stream byte per cycle. Each byte updates the record state and
// drops zero, one or two results into a three-entry result queue. The input
// is ready whenever at most one result is pending, so a byte is taken every
// cycle as long as the consumer keeps up; a final byte that also completes
// an id yields two results, an edge and then the summary. Results are
// registered in the queue before they reach the output.
module adjacency_record_stream_parser (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [32:0]              i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  arsp_pkg::t_in_item       i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output arsp_pkg::t_out_item      o_out_data
);
    import arsp_pkg::*;

    typedef enum logic [1:0] {
        PH_DEGREE,
        PH_IDS,
        PH_ERROR
    } t_phase;

    localparam logic [CountW-1:0] CountMax = '1;
    localparam logic [IdW-1:0]    IdMax    = '1;

    logic [CountW-1:0] r_min_count;

    t_phase            r_phase, n_phase;
    logic [3:0]        r_group, n_group;
    logic [63:0]       r_acc, n_acc;
    logic [63:0]       r_edges, n_edges;
    logic [1:0]        r_idx, n_idx;
    logic [23:0]       r_partial, n_partial;
    logic [CountW-1:0] r_cur, n_cur;
    logic [IdW-1:0]    r_max, n_max;

    t_out_item         r_q [3];
    t_out_item         n_q [3];
    t_out_item         sh_q [3];
    logic [1:0]        r_cnt, n_cnt;

    logic              in_xfer, out_xfer;
    logic [7:0]        b;
    logic [5:0]        shift;
    logic [63:0]       acc_or;
    logic              overflow;
    logic              have_edge;
    logic              have_sum;
    logic [IdW-1:0]    edge_id;
    logic [IdW-1:0]    edge_src;
    logic              open_rec;
    logic [CountW-1:0] nodes_read;
    logic [CountW-1:0] total;
    logic [1:0]        sum_status;
    t_out_item         res0, res1;
    logic [1:0]        nres;
    logic [1:0]        c1;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_cnt < 2'd2);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q[0];

    assign b      = i_in_data.data_byte;
    assign shift  = 6'(r_group) * 6'd7;
    assign acc_or = r_acc | ({57'd0, b[6:0]} << shift);

    // Record state update for one byte
    always_comb begin
        n_phase   = r_phase;
        n_group   = r_group;
        n_acc     = r_acc;
        n_edges   = r_edges;
        n_idx     = r_idx;
        n_partial = r_partial;
        n_cur     = r_cur;
        n_max     = r_max;
        overflow  = 1'b0;
        have_edge = 1'b0;
        edge_id   = {b, r_partial};
        edge_src  = (r_cur > {1'b0, IdMax}) ? IdMax : r_cur[IdW-1:0];

        unique case (r_phase)
            PH_DEGREE: begin
                if (r_group >= 4'd9 && b[7:1] != 7'd0) begin
                    overflow = 1'b1;
                    n_group  = 4'd9;
                    n_phase  = PH_ERROR;
                end else begin
                    n_acc = acc_or;
                    if (b[7] && r_group < 4'd9) begin
                        n_group = r_group + 4'd1;
                    end else if (acc_or == 64'd0) begin
                        // empty record completes on its last degree byte
                        n_cur   = (r_cur == CountMax) ? r_cur : r_cur + 1'b1;
                        n_group = 4'd0;
                        n_acc   = 64'd0;
                    end else begin
                        n_edges   = acc_or;
                        n_phase   = PH_IDS;
                        n_idx     = 2'd0;
                        n_partial = 24'd0;
                    end
                end
            end
            PH_IDS: begin
                case (r_idx)
                    2'd0: n_partial = {r_partial[23:8], b};
                    2'd1: n_partial = {r_partial[23:16], b, r_partial[7:0]};
                    2'd2: n_partial = {b, r_partial[15:0]};
                    default: begin
                        have_edge = 1'b1;
                        n_partial = 24'd0;
                    end
                endcase
                if (r_idx != 2'd3) begin
                    n_idx = r_idx + 2'd1;
                end else begin
                    n_idx   = 2'd0;
                    n_max   = (edge_id > r_max) ? edge_id : r_max;
                    n_edges = r_edges - 64'd1;
                    if (r_edges == 64'd1) begin
                        n_cur   = (r_cur == CountMax) ? r_cur : r_cur + 1'b1;
                        n_phase = PH_DEGREE;
                        n_group = 4'd0;
                        n_acc   = 64'd0;
                    end
                end
            end
            PH_ERROR: begin
            end
            default: begin
                n_phase = PH_DEGREE;
            end
        endcase
    end

    // Summary fields come from the state after this byte
    always_comb begin
        open_rec   = (n_phase != PH_DEGREE) || (n_group != 4'd0);
        nodes_read = (open_rec && n_cur != CountMax) ? n_cur + 1'b1 : n_cur;
        total      = (nodes_read > r_min_count) ? nodes_read : r_min_count;
        if (overflow || n_phase == PH_ERROR) begin
            sum_status = ST_OVERFLOW;
        end else if (open_rec) begin
            sum_status = ST_TRUNCATED;
        end else if ({1'b0, n_max} >= total) begin
            sum_status = ST_RANGE;
        end else begin
            sum_status = ST_OK;
        end
        have_sum = overflow || i_in_data.is_final;
    end

    always_comb begin
        t_out_item e, s;
        e.result_kind = KIND_EDGE;
        e.source_node = edge_src;
        e.target_node = edge_id;
        e.node_total  = '0;
        e.status      = ST_OK;
        e.last_of_run = !have_sum;
        s.result_kind = KIND_SUMMARY;
        s.source_node = '0;
        s.target_node = n_max;
        s.node_total  = total;
        s.status      = sum_status;
        s.last_of_run = 1'b1;
        res0 = have_edge ? e : s;
        res1 = s;
        if (!in_xfer) begin
            nres = 2'd0;
        end else begin
            nres = 2'({1'b0, have_edge} + {1'b0, have_sum});
        end
    end

    // Result queue: drain from the head, append behind what stays
    always_comb begin
        c1      = r_cnt - {1'b0, out_xfer};
        sh_q[0] = out_xfer ? r_q[1] : r_q[0];
        sh_q[1] = out_xfer ? r_q[2] : r_q[1];
        sh_q[2] = r_q[2];
        for (int k = 0; k < 3; k++) begin
            if (k < int'(c1)) begin
                n_q[k] = sh_q[k];
            end else if (k == int'(c1) && nres != 2'd0) begin
                n_q[k] = res0;
            end else if (k == int'(c1) + 1 && nres == 2'd2) begin
                n_q[k] = res1;
            end else begin
                n_q[k] = sh_q[k];
            end
        end
        n_cnt = c1 + nres;
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (!i_rst_n) begin
            r_min_count <= '0;
            r_cnt       <= 2'd0;
            r_phase     <= PH_DEGREE;
            r_group     <= 4'd0;
            r_acc       <= 64'd0;
            r_edges     <= 64'd0;
            r_idx       <= 2'd0;
            r_partial   <= 24'd0;
            r_cur       <= '0;
            r_max       <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cfg_we) begin
                r_min_count <= i_cfg_wdata;
            end
            if (in_xfer) begin
                if (i_in_data.is_final) begin
                    r_phase   <= PH_DEGREE;
                    r_group   <= 4'd0;
                    r_acc     <= 64'd0;
                    r_edges   <= 64'd0;
                    r_idx     <= 2'd0;
                    r_partial <= 24'd0;
                    r_cur     <= '0;
                    r_max     <= '0;
                end else begin
                    r_phase   <= n_phase;
                    r_group   <= n_group;
                    r_acc     <= n_acc;
                    r_edges   <= n_edges;
                    r_idx     <= n_idx;
                    r_partial <= n_partial;
                    r_cur     <= n_cur;
                    r_max     <= n_max;
                end
            end
        end
    end

endmodule

// File: src/arsp_checker.sv
// Port-level checks for the adjacency record stream parser.
// Depends on arsp_pkg; bound to adjacency_record_stream_parser.
module arsp_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     o_out_valid,
    input  logic                     i_out_ready,
    input  arsp_pkg::t_out_item      o_out_data
);
    import arsp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_edge_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == KIND_EDGE |->
            o_out_data.status == ST_OK && o_out_data.node_total == '0)
        else $error("edge carries summary fields");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == KIND_SUMMARY |->
            o_out_data.last_of_run && o_out_data.source_node == '0)
        else $error("summary not last of its byte");

endmodule

bind adjacency_record_stream_parser arsp_checker u_arsp_checker (.*);

// File: sim/adjacency_record_stream_parser_test.sv
// Self-checking bench for adjacency_record_stream_parser: random and directed byte streams,
// results predicted in-bench and compared field by field. Depends on arsp_pkg and the RTL.
module adjacency_record_stream_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import arsp_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int REPORT_LIMIT  = 10;
    localparam int DRAIN_CYCLES  = 4;

    typedef enum logic [1:0] {RD_DEGREE, RD_IDS, RD_DISCARD} t_rd_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [32:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;

    adjacency_record_stream_parser uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // parser state as the bench sees it
    logic [32:0] node_preset = '0;
    t_rd_phase   rd_phase = RD_DEGREE;
    logic [3:0]  deg_groups = '0;
    logic [63:0] deg_value = '0;
    logic [63:0] ids_left = '0;
    logic [1:0]  id_pos = '0;
    logic [23:0] id_low = '0;
    logic [32:0] nodes_done = '0;
    logic [31:0] max_target = '0;

    t_out_item   edge_summary_queue[$];
    logic [7:0]  stream_bytes[$];

    int sender_idle_max = 0;
    int receiver_idle_max = 0;
    int hold_off_cycles = 0;
    int bytes_sent = 0;
    int streams_sent = 0;
    int presets_used = 0;
    int edges_checked = 0;
    int summaries_checked = 0;
    int mismatches = 0;
    int cycle_count = 0;
    t_out_item want;

    function automatic void clear_stream();
        rd_phase   = RD_DEGREE;
        deg_groups = '0;
        deg_value  = '0;
        ids_left   = '0;
        id_pos     = '0;
        id_low     = '0;
        nodes_done = '0;
        max_target = '0;
    endfunction

    function automatic void close_record();
        if (nodes_done != '1) nodes_done++;
        rd_phase   = RD_DEGREE;
        deg_groups = '0;
        deg_value  = '0;
    endfunction

    // completed records plus the one in progress, never below the preset
    function automatic logic [32:0] nodes_so_far();
        logic [32:0] seen;
        seen = nodes_done;
        if ((rd_phase != RD_DEGREE || deg_groups != 0) && seen != '1) seen++;
        return (seen > node_preset) ? seen : node_preset;
    endfunction

    function automatic t_out_item make_summary(logic [1:0] st);
        t_out_item r;
        r = '0;
        r.result_kind = KIND_SUMMARY;
        r.target_node = max_target;
        r.node_total  = nodes_so_far();
        r.status      = st;
        return r;
    endfunction

    function automatic void decode_stream_byte(logic [7:0] b, logic fin);
        t_out_item   outs[$];
        t_out_item   r;
        logic [31:0] id;
        logic [1:0]  st;
        bit          overflow_now;
        overflow_now = 1'b0;
        case (rd_phase)
            RD_DEGREE: begin
                if (deg_groups >= 9 && (b & 8'hFE) != 0) begin
                    deg_groups = 4'd9;
                    outs.push_back(make_summary(ST_OVERFLOW));
                    rd_phase = RD_DISCARD;
                    overflow_now = 1'b1;
                end else begin
                    deg_value |= 64'(b[6:0]) << (7 * deg_groups);
                    if (b[7] && deg_groups < 9) begin
                        deg_groups++;
                    end else if (deg_value == 0) begin
                        close_record();
                    end else begin
                        ids_left = deg_value;
                        rd_phase = RD_IDS;
                        id_pos   = '0;
                        id_low   = '0;
                    end
                end
            end
            RD_IDS: begin
                if (id_pos < 3) begin
                    id_low[8*id_pos +: 8] = b;
                    id_pos++;
                end else begin
                    id = {b, id_low};
                    r = '0;
                    r.result_kind = KIND_EDGE;
                    r.source_node = nodes_done[32] ? 32'hFFFF_FFFF : nodes_done[31:0];
                    r.target_node = id;
                    outs.push_back(r);
                    if (id > max_target) max_target = id;
                    id_pos = '0;
                    id_low = '0;
                    ids_left--;
                    if (ids_left == 0) close_record();
                end
            end
            default: ;
        endcase
        if (fin) begin
            if (!overflow_now) begin
                if (rd_phase == RD_DISCARD)
                    st = ST_OVERFLOW;
                else if (rd_phase != RD_DEGREE || deg_groups != 0)
                    st = ST_TRUNCATED;
                else if ({1'b0, max_target} >= nodes_so_far())
                    st = ST_RANGE;
                else
                    st = ST_OK;
                outs.push_back(make_summary(st));
            end
            clear_stream();
        end
        foreach (outs[k]) begin
            r = outs[k];
            r.last_of_run = (k == outs.size() - 1);
            edge_summary_queue.push_back(r);
        end
    endfunction

    // valid stays up across back-to-back transfers; it drops only for a gap
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= '{data_byte: b, is_final: fin};
        do @(posedge i_clk); while (!o_in_ready);
        decode_stream_byte(b, fin);
        bytes_sent++;
        gap = $urandom_range(0, sender_idle_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (edge_summary_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_count(input logic [32:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        node_preset = value;
        presets_used++;
    endtask

    // LEB128, optionally padded with redundant zero groups
    function automatic void append_degree(logic [63:0] v, int pad);
        logic [7:0] b;
        bit         done;
        done = 1'b0;
        while (!done) begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v == 0 && pad == 0) begin
                stream_bytes.push_back(b);
                done = 1'b1;
            end else begin
                if (v == 0) pad--;
                stream_bytes.push_back(b | 8'h80);
            end
        end
    endfunction

    function automatic void append_record(int max_deg);
        int          deg;
        logic [31:0] id;
        deg = $urandom_range(0, max_deg);
        append_degree(64'(deg), ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0);
        repeat (deg) begin
            id = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 10) : $urandom;
            stream_bytes.push_back(id[7:0]);
            stream_bytes.push_back(id[15:8]);
            stream_bytes.push_back(id[23:16]);
            stream_bytes.push_back(id[31:24]);
        end
    endfunction

    task automatic send_random_stream();
        int pick;
        int cut;
        int i;
        stream_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            // well-formed records; the upper slice is cut short at a random byte
            repeat ($urandom_range(1, 4)) append_record((pick < 60) ? 3 : 6);
            if (pick >= 60) begin
                cut = $urandom_range(1, stream_bytes.size());
                while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
            end
        end else if (pick < 85) begin
            // bad tenth degree byte, then junk up to the final byte
            if ($urandom_range(0, 1) != 0) append_record(2);
            repeat (9) stream_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
            stream_bytes.push_back(8'($urandom_range(2, 255)));
            repeat ($urandom_range(0, 4)) stream_bytes.push_back(8'($urandom));
        end else if (pick < 93) begin
            append_degree({$urandom, $urandom}, 0);
            repeat ($urandom_range(0, 6)) stream_bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 8)) stream_bytes.push_back(8'($urandom));
        end
        for (i = 0; i < stream_bytes.size(); i++)
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        streams_sent++;
    endtask

    task automatic test_directed_cases();
        sender_idle_max   = 3;
        receiver_idle_max = 3;
        // empty record closing the stream, reset preset of zero
        send_byte(8'h00, 1'b1);
        // all-ones id whose last byte is also final: edge then summary
        send_byte(8'h01, 1'b0);
        repeat (3) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // overflow on the tenth degree byte, then discard to the final byte
        repeat (9) send_byte(8'hFF, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h55, 1'b1);
        // record cut off inside its first id
        send_byte(8'h02, 1'b0);
        send_byte(8'h11, 1'b1);
        // padded zero degree, then a plain zero degree
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_random_streams(input logic [32:0] preset, input int byte_target,
                                       input int send_max, input int recv_max);
        int start;
        wait_idle();
        write_min_count(preset);
        sender_idle_max   = send_max;
        receiver_idle_max = recv_max;
        start = bytes_sent;
        while (bytes_sent - start < byte_target) send_random_stream();
    endtask

    // output held off while bytes keep coming, so the input has to stall
    task automatic test_backpressure();
        int start;
        wait_idle();
        write_min_count(33'd2);
        sender_idle_max = 0;
        hold_off_cycles = 150;
        start = bytes_sent;
        while (bytes_sent - start < 60) send_random_stream();
    endtask

    initial begin : receiver
        int stall;
        wait (i_rst_n === 1'b1);
        i_out_ready <= 1'b1;
        forever begin
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            if (hold_off_cycles != 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = $urandom_range(0, receiver_idle_max);
            end
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, logic [32:0] exp_val, logic [32:0] got);
        if (got !== exp_val) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch in %s of result %0d: expected %h, got %h", name,
                         edges_checked + summaries_checked, exp_val, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (edge_summary_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %h arrived with nothing expected", o_out_data);
            end else begin
                want = edge_summary_queue.pop_front();
                check_field("result_kind", 33'(want.result_kind),
                            33'(o_out_data.result_kind));
                check_field("source_node", 33'(want.source_node),
                            33'(o_out_data.source_node));
                check_field("target_node", 33'(want.target_node),
                            33'(o_out_data.target_node));
                check_field("node_total", want.node_total, o_out_data.node_total);
                check_field("status", 33'(want.status), 33'(o_out_data.status));
                check_field("last_of_run", 33'(want.last_of_run),
                            33'(o_out_data.last_of_run));
                if (want.result_kind == KIND_EDGE) edges_checked++;
                else summaries_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
                     edge_summary_queue.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_streams(33'h1_0000_0000, 90, 18, 18);
        test_random_streams(33'd0, 90, 18, 18);
        test_random_streams(33'd1, 80, 0, 0);
        test_random_streams(33'h0_FFFF_FFFF, 80, 18, 0);
        test_random_streams(33'($urandom_range(0, 12)), 90, 0, 18);
        test_random_streams({1'b0, $urandom}, 80, 18, 18);
        test_backpressure();
        wait_idle();
        if (edge_summary_queue.size() != 0) mismatches += edge_summary_queue.size();
        $display("Sent %0d bytes in %0d random streams plus directed cases, %0d presets.",
                 bytes_sent, streams_sent, presets_used);
        $display("Checked %0d edges and %0d summaries or error reports, %0d mismatches.",
                 edges_checked, summaries_checked, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
